### rtl/aota_pkg.sv
// Shared types, codes and constants of the orientation trigger arming controller.
package aota_pkg;

    localparam int DEF_SAMPLE_DEPTH = 256;

    localparam int SAMPLE_W  = 16;
    localparam int CFG_W     = 15;
    localparam int RUN_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int LIMIT_W   = 2 * CFG_W;
    localparam int IN_W      = 3 * SAMPLE_W;
    localparam int OUT_W     = 56;

    localparam logic [CFG_W-1:0] RST_SMALL_LEVEL   = CFG_W'(820);
    localparam logic [CFG_W-1:0] RST_TILT_LEVEL    = CFG_W'(2459);
    localparam logic [CFG_W-1:0] RST_UPRIGHT_LEVEL = CFG_W'(3279);
    localparam logic [CFG_W-1:0] RST_SPREAD_LEVEL  = CFG_W'(2459);
    localparam logic [RUN_W-1:0] RST_TRIGGER_RUN   = RUN_W'(5);

    localparam logic [CFG_IDX_W-1:0] REG_SMALL_LEVEL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_LEVEL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UPRIGHT_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPREAD_LEVEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_RUN   = 3'd4;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_ARMING = 2'd1,
        MODE_ARMED  = 2'd2,
        MODE_FIRED  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_EVAL   = 2'd1,
        CMD_PRESS  = 2'd2,
        CMD_TRIPLE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PASS,
        ST_SPARE
    } t_state;

    // status of the evaluation pass over the sample store
    typedef struct packed {
        logic done;
        logic consistent;
        logic triggered;
    } t_pass_stat;

endpackage

### rtl/aota_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
module aota_div
    import aota_pkg::*;
#(
    parameter int DVD_W = 24,
    parameter int DVS_W = 9
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [DVD_W-1:0]     i_dividend,
    input  logic        [DVS_W-1:0]     i_divisor,
    output logic                        o_done,
    output logic signed [SAMPLE_W-1:0]  o_quot
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic              r_busy;
    logic              r_done;
    logic              r_neg;
    logic [STEP_W-1:0] r_step;
    logic [DVD_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W:0]    s_shift;
    logic [DVS_W+1:0]  s_diff;
    logic [DVD_W-1:0]  s_mag;
    logic [DVD_W-1:0]  s_signed_quo;

    assign s_mag   = i_dividend[DVD_W-1] ? DVD_W'(-i_dividend) : DVD_W'(i_dividend);
    assign s_shift = {r_rem, r_quo[DVD_W-1]};
    assign s_diff  = {1'b0, s_shift} - {2'b00, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg  <= i_dividend[DVD_W-1];
            r_quo  <= s_mag;
            r_rem  <= '0;
            r_step <= STEP_W'(DVD_W);
        end else if (r_busy) begin
            // restore when the trial subtraction goes negative
            if (s_diff[DVS_W+1]) begin
                r_rem <= s_shift[DVS_W-1:0];
                r_quo <= {r_quo[DVD_W-2:0], 1'b0};
            end else begin
                r_rem <= s_diff[DVS_W-1:0];
                r_quo <= {r_quo[DVD_W-2:0], 1'b1};
            end
            r_step <= r_step - STEP_W'(1);
        end
    end

    assign s_signed_quo = r_neg ? (~r_quo + DVD_W'(1)) : r_quo;
    assign o_quot       = s_signed_quo[SAMPLE_W-1:0];
    assign o_done       = r_done;

endmodule

### rtl/aota_store.sv
// Sample store: one write port and one registered read port.
module aota_store
    import aota_pkg::*;
#(
    parameter int SAMPLE_DEPTH = DEF_SAMPLE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_wr_en,
    input  logic [$clog2(SAMPLE_DEPTH)-1:0] i_wr_addr,
    input  logic [IN_W-1:0]                 i_wr_data,
    input  logic                            i_rd_en,
    input  logic [$clog2(SAMPLE_DEPTH)-1:0] i_rd_addr,
    output logic [IN_W-1:0]                 o_rd_data
);

    logic [IN_W-1:0] r_mem [SAMPLE_DEPTH];
    logic [IN_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/aota_pass.sv
// Evaluation pass: walks the store, checks spread from the mean and counts upright samples.
module aota_pass
    import aota_pkg::*;
#(
    parameter int SAMPLE_DEPTH = DEF_SAMPLE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [$clog2(SAMPLE_DEPTH+1)-1:0] i_count,
    input  logic signed [SAMPLE_W-1:0]        i_mean_x,
    input  logic signed [SAMPLE_W-1:0]        i_mean_y,
    input  logic signed [SAMPLE_W-1:0]        i_mean_z,
    input  logic [LIMIT_W-1:0]                i_limit,
    input  logic [CFG_W-1:0]                  i_small_level,
    input  logic [CFG_W-1:0]                  i_upright_level,
    input  logic [RUN_W-1:0]                  i_trigger_run,
    output logic                              o_rd_en,
    output logic [$clog2(SAMPLE_DEPTH)-1:0]   o_rd_addr,
    input  logic [IN_W-1:0]                   i_rd_data,
    output t_pass_stat                        o_stat
);

    localparam int CNT_W  = $clog2(SAMPLE_DEPTH + 1);
    localparam int ADDR_W = $clog2(SAMPLE_DEPTH);
    localparam int CMP_W  = (CNT_W > RUN_W) ? CNT_W : RUN_W;
    localparam int SQ_W   = 2 * (SAMPLE_W + 1);
    localparam int DIST_W = SQ_W + 2;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_idx;
    logic             r_v1;
    logic             r_v2;
    logic [SQ_W-1:0]  r_sq_x;
    logic [SQ_W-1:0]  r_sq_y;
    logic [SQ_W-1:0]  r_sq_z;
    logic             r_up;
    logic             r_cons;
    logic             r_trig;
    logic [CNT_W-1:0] r_upcnt;

    logic signed [SAMPLE_W-1:0] s_x, s_y, s_z;
    logic signed [SAMPLE_W:0]   s_dx, s_dy, s_dz;
    logic signed [SQ_W-1:0]     s_px, s_py, s_pz;
    logic [SAMPLE_W:0]          s_ax, s_ay, s_az;
    logic                       s_upright;
    logic [DIST_W-1:0]          s_dist;
    logic [CNT_W-1:0]           s_upcnt_inc;
    logic                       s_drained;

    assign o_rd_en   = r_busy && (r_idx < i_count);
    assign o_rd_addr = r_idx[ADDR_W-1:0];
    assign s_drained = r_busy && (r_idx == i_count) && !r_v1 && !r_v2;

    assign s_x  = i_rd_data[SAMPLE_W-1:0];
    assign s_y  = i_rd_data[2*SAMPLE_W-1:SAMPLE_W];
    assign s_z  = i_rd_data[3*SAMPLE_W-1:2*SAMPLE_W];
    assign s_dx = {i_mean_x[SAMPLE_W-1], i_mean_x} - {s_x[SAMPLE_W-1], s_x};
    assign s_dy = {i_mean_y[SAMPLE_W-1], i_mean_y} - {s_y[SAMPLE_W-1], s_y};
    assign s_dz = {i_mean_z[SAMPLE_W-1], i_mean_z} - {s_z[SAMPLE_W-1], s_z};
    assign s_px = s_dx * s_dx;
    assign s_py = s_dy * s_dy;
    assign s_pz = s_dz * s_dz;

    assign s_ax = s_x[SAMPLE_W-1] ? -{s_x[SAMPLE_W-1], s_x} : {1'b0, s_x};
    assign s_ay = s_y[SAMPLE_W-1] ? -{s_y[SAMPLE_W-1], s_y} : {1'b0, s_y};
    assign s_az = s_z[SAMPLE_W-1] ? -{s_z[SAMPLE_W-1], s_z} : {1'b0, s_z};
    assign s_upright = (s_ax < {2'b00, i_small_level}) && (s_ay < {2'b00, i_small_level})
                    && (s_az > {2'b00, i_upright_level});

    assign s_dist = {2'b00, r_sq_x} + {2'b00, r_sq_y} + {2'b00, r_sq_z};
    assign s_upcnt_inc = r_upcnt + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_v1   <= o_rd_en;
            r_v2   <= r_v1;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (s_drained) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_idx   <= '0;
            r_cons  <= 1'b1;
            r_trig  <= 1'b0;
            r_upcnt <= '0;
        end else begin
            if (o_rd_en) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            // stage two: distance check and upright count
            if (r_v2) begin
                if (s_dist > DIST_W'(i_limit)) begin
                    r_cons <= 1'b0;
                end
                if (r_up) begin
                    r_upcnt <= s_upcnt_inc;
                    if (CMP_W'(s_upcnt_inc) > CMP_W'(i_trigger_run)) begin
                        r_trig <= 1'b1;
                    end
                end
            end
        end
        // stage one: squares and upright test of the sample just read
        if (r_v1) begin
            r_sq_x <= $unsigned(s_px);
            r_sq_y <= $unsigned(s_py);
            r_sq_z <= $unsigned(s_pz);
            r_up   <= s_upright;
        end
    end

    assign o_stat.done       = r_done;
    assign o_stat.consistent = r_cons;
    assign o_stat.triggered  = r_trig;

endmodule

### rtl/accel_orientation_trigger_arm_top.sv
// Top level of the orientation trigger arming controller: channels, control and batch state.
//
// Use: items enter on the slave stream. tuser carries the command (sample, end of batch,
// button press, triple click); tdata carries the sample axes x, y, z from bit 0 up.
// Every input transaction gives exactly one result transaction on the master stream,
// describing the mode, drive, fire pulse, last batch flags and last batch means after it.
// Sample, press and triple-click items are answered directly: the result is registered in the
// cycle of acceptance and a new item may follow straight away once the result is taken.
// An end-of-batch item on an empty batch is answered the same way. Otherwise it runs the
// three axis dividers (sum width steps, one quotient bit per cycle, with sum width
// 16 + log2(SAMPLE_DEPTH)), then walks the sample store through its single read port,
// one sample per cycle, behind the store read register and the pass stage registers.
// Thresholds are written on the configuration channel, which is always
// ready; write them only while no item is in flight. Reset restores the threshold
// defaults, clears mode, sums, count, flags and means; the store content is not reset
// and is only read below the fill count. While the receiver stalls the result holds in
// the output register and no further input transaction is taken.
module accel_orientation_trigger_arm_top
    import aota_pkg::*;
#(
    parameter int SAMPLE_DEPTH = DEF_SAMPLE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_W-1:0]      s_axis_tdata,  // sample_x, sample_y, sample_z
    input  logic [1:0]           s_axis_tuser,  // command
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata   // mode, arm_drive, fire, batch_consistent,
                                                // batch_triggered, mean_x, mean_y, mean_z, pad
);

    localparam int CNT_W  = $clog2(SAMPLE_DEPTH + 1);
    localparam int ADDR_W = $clog2(SAMPLE_DEPTH);
    localparam int SUM_W  = SAMPLE_W + $clog2(SAMPLE_DEPTH);

    // configuration
    logic [CFG_W-1:0]   r_small_level;
    logic [CFG_W-1:0]   r_tilt_level;
    logic [CFG_W-1:0]   r_upright_level;
    logic [CFG_W-1:0]   r_spread_level;
    logic [RUN_W-1:0]   r_trigger_run;
    logic [LIMIT_W-1:0] r_limit;

    // batch and mode state
    t_state                     r_state, n_state;
    t_mode                      r_mode, n_mode;
    logic signed [SUM_W-1:0]    r_sum_x, r_sum_y, r_sum_z;
    logic [CNT_W-1:0]           r_count;
    logic                       r_cons, n_cons;
    logic                       r_trig, n_trig;
    logic signed [SAMPLE_W-1:0] r_mean_x, n_mean_x;
    logic signed [SAMPLE_W-1:0] r_mean_y, n_mean_y;
    logic signed [SAMPLE_W-1:0] r_mean_z, n_mean_z;
    logic                       r_out_valid;
    logic [OUT_W-1:0]           r_out_data;

    logic                       n_fire;
    logic                       s_ready;
    logic                       s_load;
    logic                       s_clear;
    logic                       s_wr;
    logic                       s_div_start;
    logic                       s_pass_start;
    logic                       s_full;
    t_cmd                       s_cmd;

    logic signed [SAMPLE_W-1:0] s_x, s_y, s_z;
    logic signed [SAMPLE_W-1:0] s_qx, s_qy, s_qz;
    logic                       s_done_x, s_done_y, s_done_z;
    logic                       s_rd_en;
    logic [ADDR_W-1:0]          s_rd_addr;
    logic [IN_W-1:0]            s_rd_data;
    t_pass_stat                 s_stat;

    logic [SAMPLE_W:0]          s_abs_mx;
    logic signed [SAMPLE_W:0]   s_my_ext, s_mz_ext;
    logic signed [SAMPLE_W:0]   s_small_ext, s_tilt_neg, s_up_ext;

    assign s_cmd  = t_cmd'(s_axis_tuser);
    assign s_x    = s_axis_tdata[SAMPLE_W-1:0];
    assign s_y    = s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
    assign s_z    = s_axis_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
    assign s_full = (r_count == CNT_W'(SAMPLE_DEPTH));

    // mean comparisons for the mode decision, all in 17 bits, signed except the x magnitude
    assign s_abs_mx    = r_mean_x[SAMPLE_W-1] ? -{r_mean_x[SAMPLE_W-1], r_mean_x}
                                              : {1'b0, r_mean_x};
    assign s_my_ext    = {r_mean_y[SAMPLE_W-1], r_mean_y};
    assign s_mz_ext    = {r_mean_z[SAMPLE_W-1], r_mean_z};
    assign s_small_ext = $signed({2'b00, r_small_level});
    assign s_tilt_neg  = -$signed({2'b00, r_tilt_level});
    assign s_up_ext    = $signed({2'b00, r_upright_level});

    // configuration writes; the channel never stalls
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_small_level   <= RST_SMALL_LEVEL;
            r_tilt_level    <= RST_TILT_LEVEL;
            r_upright_level <= RST_UPRIGHT_LEVEL;
            r_spread_level  <= RST_SPREAD_LEVEL;
            r_trigger_run   <= RST_TRIGGER_RUN;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SMALL_LEVEL:   r_small_level   <= i_cfg_data;
                REG_TILT_LEVEL:    r_tilt_level    <= i_cfg_data;
                REG_UPRIGHT_LEVEL: r_upright_level <= i_cfg_data;
                REG_SPREAD_LEVEL:  r_spread_level  <= i_cfg_data;
                REG_TRIGGER_RUN:   r_trigger_run   <= i_cfg_data[RUN_W-1:0];
                default:           ; // drop writes beyond the register list
            endcase
        end
    end

    // squared spread limit, settled long before the pass uses it
    always_ff @(posedge i_clk) begin
        r_limit <= r_spread_level * r_spread_level;
    end

    // sequencer: next state, next mode and flags, strobes
    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_cons       = r_cons;
        n_trig       = r_trig;
        n_mean_x     = r_mean_x;
        n_mean_y     = r_mean_y;
        n_mean_z     = r_mean_z;
        n_fire       = 1'b0;
        s_ready      = 1'b0;
        s_load       = 1'b0;
        s_clear      = 1'b0;
        s_wr         = 1'b0;
        s_div_start  = 1'b0;
        s_pass_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_ready = !r_out_valid || m_axis_tready;
                if (s_ready && s_axis_tvalid) begin
                    unique case (s_cmd)
                        CMD_SAMPLE: begin
                            s_wr   = !s_full;
                            s_load = 1'b1;
                        end
                        CMD_EVAL: begin
                            if (r_count == '0) begin
                                // empty batch: zero means, consistent, not triggered
                                n_cons   = 1'b1;
                                n_trig   = 1'b0;
                                n_mean_x = '0;
                                n_mean_y = '0;
                                n_mean_z = '0;
                                if (r_mode == MODE_ARMING) begin
                                    n_mode = MODE_IDLE;
                                end
                                s_clear = 1'b1;
                                s_load  = 1'b1;
                            end else begin
                                s_div_start = 1'b1;
                                n_state     = ST_DIV;
                            end
                        end
                        CMD_PRESS: begin
                            if (r_mode != MODE_FIRED) begin
                                n_mode = MODE_IDLE;
                            end
                            s_load = 1'b1;
                        end
                        CMD_TRIPLE: begin
                            if (r_mode == MODE_IDLE) begin
                                n_mode = MODE_ARMING;
                            end
                            s_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (s_done_x && s_done_y && s_done_z) begin
                    n_mean_x     = s_qx;
                    n_mean_y     = s_qy;
                    n_mean_z     = s_qz;
                    s_pass_start = 1'b1;
                    n_state      = ST_PASS;
                end
            end
            ST_PASS: begin
                if (s_stat.done) begin
                    n_cons = s_stat.consistent;
                    n_trig = s_stat.triggered;
                    if (r_mode == MODE_ARMING) begin
                        if (s_stat.consistent && !s_stat.triggered
                            && (s_abs_mx < {2'b00, r_small_level})
                            && (s_my_ext < s_tilt_neg) && (s_mz_ext > s_up_ext)) begin
                            n_mode = MODE_ARMED;
                        end else begin
                            n_mode = MODE_IDLE;
                        end
                    end else if (r_mode == MODE_ARMED) begin
                        if (s_stat.triggered) begin
                            n_mode = MODE_FIRED;
                            n_fire = 1'b1;
                        end else if ((s_abs_mx > {2'b00, r_small_level})
                                     || (s_my_ext > s_small_ext) || (s_mz_ext < s_up_ext)) begin
                            n_mode = MODE_IDLE;
                        end
                    end
                    s_clear = 1'b1;
                    s_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_SPARE: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign s_axis_tready = s_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_IDLE;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_sum_z     <= '0;
            r_count     <= '0;
            r_cons      <= 1'b0;
            r_trig      <= 1'b0;
            r_mean_x    <= '0;
            r_mean_y    <= '0;
            r_mean_z    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_cons   <= n_cons;
            r_trig   <= n_trig;
            r_mean_x <= n_mean_x;
            r_mean_y <= n_mean_y;
            r_mean_z <= n_mean_z;
            if (s_clear) begin
                r_sum_x <= '0;
                r_sum_y <= '0;
                r_sum_z <= '0;
                r_count <= '0;
            end else if (s_wr) begin
                r_sum_x <= r_sum_x + {{(SUM_W-SAMPLE_W){s_x[SAMPLE_W-1]}}, s_x};
                r_sum_y <= r_sum_y + {{(SUM_W-SAMPLE_W){s_y[SAMPLE_W-1]}}, s_y};
                r_sum_z <= r_sum_z + {{(SUM_W-SAMPLE_W){s_z[SAMPLE_W-1]}}, s_z};
                r_count <= r_count + CNT_W'(1);
            end
            // hold the result until the receiver takes it
            if (s_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_load) begin
            r_out_data <= {2'b00, n_mean_z, n_mean_y, n_mean_x, n_trig, n_cons, n_fire,
                           (n_mode == MODE_ARMED), n_mode};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // one divider per axis, all started together and finishing together
    aota_div #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_div_start),
        .i_dividend (r_sum_x),
        .i_divisor  (r_count),
        .o_done     (s_done_x),
        .o_quot     (s_qx)
    );

    aota_div #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_div_start),
        .i_dividend (r_sum_y),
        .i_divisor  (r_count),
        .o_done     (s_done_y),
        .o_quot     (s_qy)
    );

    aota_div #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_div_z (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_div_start),
        .i_dividend (r_sum_z),
        .i_divisor  (r_count),
        .o_done     (s_done_z),
        .o_quot     (s_qz)
    );

    aota_store #(.SAMPLE_DEPTH(SAMPLE_DEPTH)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (s_wr),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (s_axis_tdata),
        .i_rd_en   (s_rd_en),
        .i_rd_addr (s_rd_addr),
        .o_rd_data (s_rd_data)
    );

    aota_pass #(.SAMPLE_DEPTH(SAMPLE_DEPTH)) u_pass (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (s_pass_start),
        .i_count         (r_count),
        .i_mean_x        (r_mean_x),
        .i_mean_y        (r_mean_y),
        .i_mean_z        (r_mean_z),
        .i_limit         (r_limit),
        .i_small_level   (r_small_level),
        .i_upright_level (r_upright_level),
        .i_trigger_run   (r_trigger_run),
        .o_rd_en         (s_rd_en),
        .o_rd_addr       (s_rd_addr),
        .i_rd_data       (s_rd_data),
        .o_stat          (s_stat)
    );

endmodule
